[hw/rtl/tsqd_pkg.sv]
package tsqd_pkg;

    localparam int TICK_W  = 32;
    localparam int SVC_W   = 2;
    localparam int WAIT_W  = 10;
    localparam int LEN_W   = 5;
    localparam int SUM_W   = 32;
    localparam int CAP_W   = 5;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 168;

    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    typedef struct packed {
        logic [SVC_W-1:0]  svc;
        logic [TICK_W-1:0] arrive;
    } t_entry;

    // fields from the lowest bit up, reversed here because packed structs list msb first
    typedef struct packed {
        logic [5:0]        pad;
        logic [SUM_W-1:0]  total_turnaways;
        logic [SUM_W-1:0]  total_length;
        logic [SUM_W-1:0]  total_wait;
        logic [SUM_W-1:0]  total_served;
        logic [LEN_W-1:0]  length_b;
        logic [LEN_W-1:0]  length_a;
        logic [WAIT_W-1:0] wait_b;
        logic              start_b;
        logic [WAIT_W-1:0] wait_a;
        logic              start_a;
        logic              turned_away;
        logic              accepted;
    } t_result;

endpackage

[hw/rtl/two_server_shorter_queue_dispatch_core.sv]
// Two-server join-the-shorter-queue dispatcher. Each input beat is one tick carrying an
// optional arrival and its service time; each tick yields exactly one result beat with
// the admission decision, the jobs started on servers A and B with their waits, both queue
// lengths and four wrapping running totals. On accept the arriving entry is written to its
// queue memory and both queue heads are read; the execute state, which waits while an
// untaken result holds the output, then starts jobs from the registered head data and
// updates timers, counts, totals and the output register. No beat is taken until the last
// tick, whose counts it needs, commits. The queue stores need no clearing, so beats are
// taken straight from reset. The user must write the capacity register (reset 10, limited
// to QUEUE_DEPTH) through the cfg channel only while idle; the block does not enforce it.
module two_server_shorter_queue_dispatch_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tsqd_pkg::CAP_W-1:0]  i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // arrival, service_time, zero fill
    input  logic [tsqd_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // accepted, turned_away, start_a, wait_a, start_b, wait_b, length_a, length_b,
    // total_served, total_wait, total_length, total_turnaways, zero fill
    output logic [tsqd_pkg::OUT_W-1:0]  m_axis_tdata
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int WW = (CW > tsqd_pkg::CAP_W) ? CW : tsqd_pkg::CAP_W;
    localparam logic [WW-1:0] DEPTH_W = WW'(QUEUE_DEPTH);
    localparam logic [AW:0] DEPTH_A = (AW+1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_A = AW'(QUEUE_DEPTH - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    tsqd_pkg::t_entry mem_a [QUEUE_DEPTH];
    tsqd_pkg::t_entry mem_b [QUEUE_DEPTH];

    logic                          r_state;
    logic [tsqd_pkg::CAP_W-1:0]    r_cap;
    logic [tsqd_pkg::TICK_W-1:0]   r_tick;
    logic [AW-1:0]                 r_head_a, r_head_b;
    logic [CW-1:0]                 r_cnt_a, r_cnt_b;
    logic [tsqd_pkg::SVC_W-1:0]    r_tmr_a, r_tmr_b;
    logic [tsqd_pkg::SUM_W-1:0]    r_served, r_wait, r_len, r_away_sum;
    tsqd_pkg::t_entry              r_rd_a, r_rd_b;
    logic                          r_acc, r_away, r_push_a, r_push_b, r_fwd_a, r_fwd_b;
    logic [tsqd_pkg::SVC_W-1:0]    r_svc;
    logic                          r_ov;
    tsqd_pkg::t_result             r_out;

    logic                          in_fire, commit;
    logic                          arr;
    logic [tsqd_pkg::SVC_W-1:0]    svc;
    logic [WW-1:0]                 cap_eff, cnt_a_w, cnt_b_w;
    logic                          full_a, full_b, away, push_a, push_b;
    logic [AW:0]                   tail_a_s, tail_b_s;
    logic [AW-1:0]                 tail_a, tail_b;
    tsqd_pkg::t_entry              wr_ent, ea, eb;
    logic [CW-1:0]                 cnt_pa, cnt_pb;
    logic                          sa, sb;
    logic [tsqd_pkg::SVC_W-1:0]    tl_a, tl_b;
    logic [tsqd_pkg::TICK_W-1:0]   wa, wb, wa_r, wb_r;
    logic [CW-1:0]                 n_cnt_a, n_cnt_b;
    logic [WW-1:0]                 len_a_w, len_b_w;
    logic [tsqd_pkg::SUM_W-1:0]    n_served, n_wait, n_len;
    tsqd_pkg::t_result             n_out;

    assign arr = s_axis_tdata[0];
    assign svc = s_axis_tdata[2:1];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign commit        = (r_state == ST_EXEC) && (!r_ov || m_axis_tready);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    // admission, done against the counts left by the previous tick
    always_comb begin
        cap_eff  = (WW'(r_cap) > DEPTH_W) ? DEPTH_W : WW'(r_cap);
        cnt_a_w  = WW'(r_cnt_a);
        cnt_b_w  = WW'(r_cnt_b);
        full_a   = cnt_a_w >= cap_eff;
        full_b   = cnt_b_w >= cap_eff;
        away     = arr && full_a && full_b;
        push_a   = arr && !away && (r_cnt_b >= r_cnt_a);
        push_b   = arr && !away && !(r_cnt_b >= r_cnt_a);
        tail_a_s = (AW+1)'(r_head_a) + (AW+1)'(r_cnt_a);
        tail_b_s = (AW+1)'(r_head_b) + (AW+1)'(r_cnt_b);
        tail_a   = (tail_a_s >= DEPTH_A) ? AW'(tail_a_s - DEPTH_A) : tail_a_s[AW-1:0];
        tail_b   = (tail_b_s >= DEPTH_A) ? AW'(tail_b_s - DEPTH_A) : tail_b_s[AW-1:0];
        wr_ent.svc    = svc;
        wr_ent.arrive = r_tick;
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && push_a) begin
            mem_a[tail_a] <= wr_ent;
        end
        if (in_fire && push_b) begin
            mem_b[tail_b] <= wr_ent;
        end
        if (in_fire) begin
            r_rd_a <= mem_a[r_head_a];
            r_rd_b <= mem_b[r_head_b];
        end
    end

    // service, with the arriving entry forwarded when it lands on an empty queue
    always_comb begin
        ea.svc    = r_fwd_a ? r_svc : r_rd_a.svc;
        ea.arrive = r_fwd_a ? r_tick : r_rd_a.arrive;
        eb.svc    = r_fwd_b ? r_svc : r_rd_b.svc;
        eb.arrive = r_fwd_b ? r_tick : r_rd_b.arrive;
        cnt_pa  = r_cnt_a + CW'(r_push_a);
        cnt_pb  = r_cnt_b + CW'(r_push_b);
        sa      = (r_tmr_a == '0) && (cnt_pa != '0);
        sb      = (r_tmr_b == '0) && (cnt_pb != '0);
        tl_a    = sa ? ea.svc : r_tmr_a;
        tl_b    = sb ? eb.svc : r_tmr_b;
        n_cnt_a = cnt_pa - CW'(sa);
        n_cnt_b = cnt_pb - CW'(sb);
        wa      = sa ? (r_tick - ea.arrive) : '0;
        wb      = sb ? (r_tick - eb.arrive) : '0;
        wa_r    = wa;
        wb_r    = wb;
        len_a_w = WW'(n_cnt_a);
        len_b_w = WW'(n_cnt_b);
        n_served = r_served + tsqd_pkg::SUM_W'(sa) + tsqd_pkg::SUM_W'(sb);
        n_wait   = r_wait + wa + wb;
        n_len    = r_len + tsqd_pkg::SUM_W'(n_cnt_a) + tsqd_pkg::SUM_W'(n_cnt_b);

        n_out                 = '0;
        n_out.accepted        = r_acc;
        n_out.turned_away     = r_away;
        n_out.start_a         = sa;
        n_out.wait_a          = (wa_r > tsqd_pkg::TICK_W'(tsqd_pkg::WAIT_MAX)) ?
                                tsqd_pkg::WAIT_MAX : wa_r[tsqd_pkg::WAIT_W-1:0];
        n_out.start_b         = sb;
        n_out.wait_b          = (wb_r > tsqd_pkg::TICK_W'(tsqd_pkg::WAIT_MAX)) ?
                                tsqd_pkg::WAIT_MAX : wb_r[tsqd_pkg::WAIT_W-1:0];
        n_out.length_a        = len_a_w[tsqd_pkg::LEN_W-1:0];
        n_out.length_b        = len_b_w[tsqd_pkg::LEN_W-1:0];
        n_out.total_served    = n_served;
        n_out.total_wait      = n_wait;
        n_out.total_length    = n_len;
        n_out.total_turnaways = r_away_sum;
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_acc    <= arr && !away;
            r_away   <= away;
            r_push_a <= push_a;
            r_push_b <= push_b;
            r_fwd_a  <= push_a && (r_cnt_a == '0);
            r_fwd_b  <= push_b && (r_cnt_b == '0);
            r_svc    <= svc;
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cap      <= tsqd_pkg::CAP_W'(10);
            r_tick     <= '0;
            r_head_a   <= '0;
            r_head_b   <= '0;
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_tmr_a    <= '0;
            r_tmr_b    <= '0;
            r_served   <= '0;
            r_wait     <= '0;
            r_len      <= '0;
            r_away_sum <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (commit) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_state <= ST_EXEC;
                        if (away) begin
                            r_away_sum <= r_away_sum + 1'b1;
                        end
                    end
                end
                ST_EXEC: begin
                    if (commit) begin
                        r_state  <= ST_IDLE;
                        r_tick   <= r_tick + 1'b1;
                        r_cnt_a  <= n_cnt_a;
                        r_cnt_b  <= n_cnt_b;
                        r_tmr_a  <= (tl_a != '0) ? tl_a - 1'b1 : tl_a;
                        r_tmr_b  <= (tl_b != '0) ? tl_b - 1'b1 : tl_b;
                        r_served <= n_served;
                        r_wait   <= n_wait;
                        r_len    <= n_len;
                        if (sa) begin
                            r_head_a <= (r_head_a == LAST_A) ? '0 : r_head_a + 1'b1;
                        end
                        if (sb) begin
                            r_head_b <= (r_head_b == LAST_A) ? '0 : r_head_b + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input taken while a tick is in progress");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CW'(QUEUE_DEPTH)) && (r_cnt_b <= CW'(QUEUE_DEPTH)))
        else $error("queue count beyond depth");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> m_axis_tvalid && s_axis_tready)
        else $error("committed tick did not present a result");

    a_excl_admit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_out.accepted && r_out.turned_away))
        else $error("arrival both accepted and turned away");

    a_idle_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_out.start_a) |-> (r_out.wait_a == '0))
        else $error("wait reported without a start on server a");

endmodule
